/* design/tcd_pkg.sv */
// Shared types, constants and the effect remapping function for the track cell decoder.
// Used by tcd_ctrl, tcd_datapath and tracker_track_cell_decoder_core; depends on nothing.
package tcd_pkg;

	localparam int TRACK_ROWS_DEF = 64;
	localparam int MAX_RESULTS    = 64;
	localparam int COUNT_W        = $clog2(MAX_RESULTS + 1);
	localparam int SPAN_W         = 9;

	localparam logic [7:0] MARKER_BYTE  = 8'hFC;
	localparam logic [7:0] SPECIAL_FX   = 8'h99;
	localparam logic [7:0] NOTE_OFFSET  = 8'd24;
	localparam logic [5:0] FX_SPECIAL_A = 6'h22;
	localparam logic [5:0] FX_PORTA     = 6'h03;
	localparam logic [5:0] FX_VIBRATO   = 6'h23;
	localparam logic [5:0] FX_TREMOLO   = 6'h21;
	localparam logic [5:0] FX_PAN       = 6'h08;
	localparam logic [5:0] FX_EXTENDED  = 6'h30;
	localparam logic [5:0] FX_TEMPO     = 6'h16;
	localparam logic [5:0] FX_SPEED     = 6'h1C;
	localparam logic [5:0] FX_NONE      = 6'h00;
	localparam logic [7:0] TEMPO_MIN    = 8'h30;

	typedef struct packed {
		logic [5:0] eff;
		logic [7:0] op;
	} tcd_fx_t;

	typedef struct packed {
		logic load_note;
		logic load_repeat;
		logic load_instr;
		logic load_effects;
		logic load_opb;
		logic load_opa;
		logic emit;
		logic last;
	} tcd_cmd_t;

	typedef struct packed {
		logic               is_marker;
		logic               slot_free;
		logic [COUNT_W-1:0] count;
	} tcd_status_t;

	function automatic tcd_fx_t map_effect(input logic [3:0] e, input logic [7:0] o);
		tcd_fx_t r;
		r.eff = {2'b00, e};
		r.op  = o;
		case (e)
			4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h7, 4'hA, 4'hC, 4'hD: begin
				r.eff = {2'b00, e};
			end
			4'h5: r.eff = FX_VIBRATO;
			4'h9: r.eff = FX_TREMOLO;
			4'hB: begin
				r.eff = FX_PAN;
				r.op  = (o[7:4] != 4'h0) ? 8'hFF : {o[3:0], 4'h0};
			end
			4'hE: begin
				r.eff = FX_EXTENDED + {2'b00, o[7:4]};
				r.op  = {4'h0, o[3:0]};
			end
			4'hF: r.eff = (o >= TEMPO_MIN) ? FX_TEMPO : FX_SPEED;
			default: begin
				r.eff = FX_NONE;
				r.op  = 8'h00;
			end
		endcase
		return r;
	endfunction

endpackage

/* design/tcd_ctrl.sv */
// Controller of the track cell decoder: walks the cell byte phases and sequences slot runs.
// Depends on tcd_pkg for the command and status structs.
module tcd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  tcd_pkg::tcd_status_t status,
	output tcd_pkg::tcd_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_NOTE,
		ST_REPEAT,
		ST_NOTE_AFTER_REPEAT,
		ST_INSTR,
		ST_EFFECT,
		ST_OPB,
		ST_OPA,
		ST_EMIT
	} state_t;

	state_t                       state_q;
	logic [tcd_pkg::COUNT_W-1:0]  slots_left_q;
	logic                         take;

	assign byte_stall = (state_q == ST_EMIT);
	assign take       = byte_valid && !byte_stall;

	always_comb begin
		cmd              = '0;
		cmd.load_note    = take && (((state_q == ST_NOTE) && !status.is_marker) ||
		                            (state_q == ST_NOTE_AFTER_REPEAT));
		cmd.load_repeat  = take && (state_q == ST_REPEAT);
		cmd.load_instr   = take && (state_q == ST_INSTR);
		cmd.load_effects = take && (state_q == ST_EFFECT);
		cmd.load_opb     = take && (state_q == ST_OPB);
		cmd.load_opa     = take && (state_q == ST_OPA);
		cmd.emit         = (state_q == ST_EMIT) && status.slot_free;
		cmd.last         = (slots_left_q == tcd_pkg::COUNT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_NOTE;
			slots_left_q <= '0;
		end else begin
			case (state_q)
				ST_NOTE: begin
					if (take) begin
						state_q <= status.is_marker ? ST_REPEAT : ST_INSTR;
					end
				end
				ST_REPEAT: begin
					if (take) begin
						state_q <= ST_NOTE_AFTER_REPEAT;
					end
				end
				ST_NOTE_AFTER_REPEAT: begin
					if (take) begin
						state_q <= ST_INSTR;
					end
				end
				ST_INSTR: begin
					if (take) begin
						state_q <= ST_EFFECT;
					end
				end
				ST_EFFECT: begin
					if (take) begin
						state_q <= ST_OPB;
					end
				end
				ST_OPB: begin
					if (take) begin
						state_q <= ST_OPA;
					end
				end
				ST_OPA: begin
					if (take) begin
						slots_left_q <= status.count;
						state_q      <= (status.count == '0) ? ST_NOTE : ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cmd.emit) begin
						slots_left_q <= slots_left_q - tcd_pkg::COUNT_W'(1);
						if (cmd.last) begin
							state_q <= ST_NOTE;
						end
					end
				end
				default: state_q <= ST_NOTE;
			endcase
		end
	end

endmodule

/* design/tcd_datapath.sv */
// Datapath of the track cell decoder: held cell bytes, row and portamento state,
// slot conversion and the output register. Depends on tcd_pkg.
module tcd_datapath #(
	parameter int TRACK_ROWS = tcd_pkg::TRACK_ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           stream_byte,
	input  tcd_pkg::tcd_cmd_t    cmd,
	output tcd_pkg::tcd_status_t status,
	output logic                 slot_valid,
	input  logic                 slot_stall,
	output logic [7:0]           note_out,
	output logic [7:0]           instrument_out,
	output logic [5:0]           effect_a,
	output logic [7:0]           operand_a,
	output logic [5:0]           effect_b,
	output logic [7:0]           operand_b,
	output logic [5:0]           row_index,
	output logic                 run_last
);

	localparam int ROW_W = (TRACK_ROWS > 1) ? $clog2(TRACK_ROWS) : 1;
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(TRACK_ROWS - 1);
	localparam logic [tcd_pkg::SPAN_W-1:0] SPAN_ROWS = tcd_pkg::SPAN_W'(TRACK_ROWS);
	localparam logic [tcd_pkg::SPAN_W-1:0] SPAN_MAX  = tcd_pkg::SPAN_W'(tcd_pkg::MAX_RESULTS);

	logic [7:0]       held_note_q;
	logic [7:0]       held_instr_q;
	logic [7:0]       held_fx_q;
	logic [7:0]       held_opb_q;
	logic [7:0]       held_opa_q;
	logic [7:0]       repeat_q;
	logic [ROW_W-1:0] row_q;
	logic [1:0]       porta_q;
	logic             slot_valid_q;

	logic [7:0] note_q;
	logic [7:0] instr_q;
	logic [5:0] eff_a_q;
	logic [7:0] op_a_q;
	logic [5:0] eff_b_q;
	logic [7:0] op_b_q;
	logic [5:0] row_idx_q;
	logic       last_q;

	logic [tcd_pkg::SPAN_W-1:0] row_wide;
	logic [tcd_pkg::SPAN_W-1:0] rows_left;
	logic [tcd_pkg::SPAN_W-1:0] rep_wide;
	logic [tcd_pkg::SPAN_W-1:0] clip_rows;
	logic [7:0]                 slot_note;
	tcd_pkg::tcd_fx_t           fx_a;
	tcd_pkg::tcd_fx_t           fx_b;
	logic [1:0]                 porta_next;

	assign row_wide  = tcd_pkg::SPAN_W'(row_q);
	assign rows_left = SPAN_ROWS - row_wide;
	assign rep_wide  = tcd_pkg::SPAN_W'(repeat_q);
	assign clip_rows = (rep_wide < rows_left) ? rep_wide : rows_left;

	assign status.is_marker = (stream_byte == tcd_pkg::MARKER_BYTE);
	assign status.slot_free = !slot_valid_q || !slot_stall;
	assign status.count     = (clip_rows > SPAN_MAX) ? tcd_pkg::COUNT_W'(tcd_pkg::MAX_RESULTS)
	                                                 : tcd_pkg::COUNT_W'(clip_rows);

	always_comb begin
		slot_note = (held_note_q != 8'h00) ? held_note_q + tcd_pkg::NOTE_OFFSET : 8'h00;
		if (held_fx_q == tcd_pkg::SPECIAL_FX) begin
			fx_a.eff = tcd_pkg::FX_SPECIAL_A;
			fx_a.op  = held_opa_q;
			fx_b.eff = tcd_pkg::FX_NONE;
			fx_b.op  = held_opb_q;
		end else begin
			fx_a = tcd_pkg::map_effect(held_fx_q[7:4], held_opa_q);
			fx_b = tcd_pkg::map_effect(held_fx_q[3:0], held_opb_q);
		end
		if (porta_q[0] && (slot_note == 8'h00)) begin
			fx_a.eff = tcd_pkg::FX_PORTA;
			fx_a.op  = 8'h00;
		end
		if (porta_q[1] && (slot_note == 8'h00)) begin
			fx_b.eff = tcd_pkg::FX_PORTA;
			fx_b.op  = 8'h00;
		end
		porta_next = porta_q;
		if (slot_note != 8'h00) begin
			porta_next[0] = (fx_a.eff == tcd_pkg::FX_PORTA) && (fx_a.op != 8'h00);
			porta_next[1] = (fx_b.eff == tcd_pkg::FX_PORTA) && (fx_b.op != 8'h00);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_q     <= 8'd1;
			row_q        <= '0;
			porta_q      <= 2'b00;
			slot_valid_q <= 1'b0;
		end else begin
			if (cmd.load_repeat) begin
				repeat_q <= stream_byte;
			end else if (cmd.load_opa) begin
				repeat_q <= 8'd1;
			end
			if (cmd.emit) begin
				slot_valid_q <= 1'b1;
				if (row_q == ROW_LAST) begin
					row_q   <= '0;
					porta_q <= 2'b00;
				end else begin
					row_q   <= row_q + ROW_W'(1);
					porta_q <= porta_next;
				end
			end else if (!slot_stall) begin
				slot_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_note) begin
			held_note_q <= stream_byte;
		end
		if (cmd.load_instr) begin
			held_instr_q <= stream_byte;
		end
		if (cmd.load_effects) begin
			held_fx_q <= stream_byte;
		end
		if (cmd.load_opb) begin
			held_opb_q <= stream_byte;
		end
		if (cmd.load_opa) begin
			held_opa_q <= stream_byte;
		end
		if (cmd.emit) begin
			note_q    <= slot_note;
			instr_q   <= held_instr_q;
			eff_a_q   <= fx_a.eff;
			op_a_q    <= fx_a.op;
			eff_b_q   <= fx_b.eff;
			op_b_q    <= fx_b.op;
			row_idx_q <= row_wide[5:0];
			last_q    <= cmd.last;
		end
	end

	assign slot_valid     = slot_valid_q;
	assign note_out       = note_q;
	assign instrument_out = instr_q;
	assign effect_a       = eff_a_q;
	assign operand_a      = op_a_q;
	assign effect_b       = eff_b_q;
	assign operand_b      = op_b_q;
	assign row_index      = row_idx_q;
	assign run_last       = last_q;

endmodule

/* design/tracker_track_cell_decoder_core.sv */
// Top level of the track cell decoder: joins the phase controller and the slot datapath.
// Depends on tcd_pkg, tcd_ctrl and tcd_datapath.
//
// The block takes one coded track byte per cycle while byte_stall is low and converts each
// completed cell into pattern slots, one per row. Bytes that do not close a cell are taken
// at one per cycle with no stall. After the closing byte of a cell that yields n slots
// (its repeat count, clipped at the track end and at 64), the byte channel is held while the
// slot generator produces one slot per cycle into a single output register, unless the
// slot channel stalls. A cell with repeat count zero yields no slot and does not hold the
// byte channel. Slots appear in the cycle after they are generated, and the byte channel
// reopens in the cycle after a run's last slot is generated, even if it is not yet taken.
module tracker_track_cell_decoder_core #(
	parameter int TRACK_ROWS = tcd_pkg::TRACK_ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] stream_byte,
	output logic       slot_valid,
	input  logic       slot_stall,
	output logic [7:0] note_out,
	output logic [7:0] instrument_out,
	output logic [5:0] effect_a,
	output logic [7:0] operand_a,
	output logic [5:0] effect_b,
	output logic [7:0] operand_b,
	output logic [5:0] row_index,
	output logic       run_last
);

	tcd_pkg::tcd_cmd_t    cmd;
	tcd_pkg::tcd_status_t status;

	tcd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.status     (status),
		.cmd        (cmd)
	);

	tcd_datapath #(
		.TRACK_ROWS (TRACK_ROWS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.stream_byte    (stream_byte),
		.cmd            (cmd),
		.status         (status),
		.slot_valid     (slot_valid),
		.slot_stall     (slot_stall),
		.note_out       (note_out),
		.instrument_out (instrument_out),
		.effect_a       (effect_a),
		.operand_a      (operand_a),
		.effect_b       (effect_b),
		.operand_b      (operand_b),
		.row_index      (row_index),
		.run_last       (run_last)
	);

endmodule
